>>> hdl/cxpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the xorshift step for the chained xorshift packet cipher.
// No dependencies; imported by every module of the block.
package cxpc_pkg;

	localparam int unsigned DATA_W        = 64;
	localparam int unsigned SEQ_W         = 16;
	localparam int unsigned TS_W          = 32;
	localparam int unsigned SEED_W        = 32;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned APB_DATA_W    = 32;
	localparam int unsigned APB_ADDR_W    = 4;
	localparam int unsigned MAX_BYTES     = 8;
	localparam int unsigned PAYLOAD_BYTES_DEF = 8;

	localparam logic [SEED_W-1:0] SEQ_MIX = 32'h045D_9F3B;

	typedef enum logic [1:0] {
		REG_CIPHER_KEY  = 2'd0,
		REG_INIT_VECTOR = 2'd1,
		REG_WEYL_INCR   = 2'd2
	} cxpc_reg_t;

	typedef struct packed {
		logic [SEED_W-1:0] cipher_key;
		logic [BYTE_W-1:0] init_vector;
		logic [SEED_W-1:0] weyl_increment;
	} cxpc_cfg_t;

	typedef struct packed {
		logic              dec;
		logic [SEED_W-1:0] seed;
		logic [BYTE_W-1:0] chain;
		logic [DATA_W-1:0] data;
	} cxpc_lane_t;

	function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

>>> hdl/chained_xorshift_packet_cipher_core.sv
`timescale 1ns / 1ps
// Chained xorshift packet cipher, top level.
// Throughput: one request per cycle while in_stall is low; one seed stage (16x32 multiply) then one stage per byte.
// Stalls back up stage by stage; bubbles are squeezed out, nothing is dropped or repeated.
// Reset clears all stage valid bits and sets the three config registers to zero.
module chained_xorshift_packet_cipher_core
	import cxpc_pkg::*;
#(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [SEQ_W-1:0]      seq_id,
	input  logic [TS_W-1:0]       timestamp,
	input  logic [DATA_W-1:0]     payload_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_W-1:0]     payload_out
);

	localparam int unsigned NB = (PAYLOAD_BYTES > MAX_BYTES) ? MAX_BYTES :
	                             (PAYLOAD_BYTES < 1) ? 1 : PAYLOAD_BYTES;

	cxpc_cfg_t  cfg;
	cxpc_lane_t lane  [NB+1];
	logic       vld   [NB+1];
	logic       stl   [NB+1];

	cxpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cxpc_seed u_seed (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_in   (in_valid),
		.stall_out  (in_stall),
		.op         (op),
		.seq_id     (seq_id),
		.timestamp  (timestamp),
		.payload_in (payload_in),
		.valid_out  (vld[0]),
		.stall_in   (stl[0]),
		.lane_out   (lane[0])
	);

	for (genvar k = 0; k < NB; k++) begin : g_round
		cxpc_round #(
			.BYTE_IDX (k)
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.valid_in  (vld[k]),
			.stall_out (stl[k]),
			.lane_in   (lane[k]),
			.valid_out (vld[k+1]),
			.stall_in  (stl[k+1]),
			.lane_out  (lane[k+1])
		);
	end

	assign stl[NB]     = out_stall;
	assign out_valid   = vld[NB];
	assign payload_out = lane[NB].data;

endmodule

>>> hdl/cxpc_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: key, initial chain byte, Weyl increment.
// Depends on cxpc_pkg.
module cxpc_regs
	import cxpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cxpc_cfg_t             cfg
);

	logic [SEED_W-1:0] key_q;
	logic [BYTE_W-1:0] iv_q;
	logic [SEED_W-1:0] weyl_q;
	logic              wr_en;
	cxpc_reg_t         reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = cxpc_reg_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			iv_q   <= '0;
			weyl_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_CIPHER_KEY:  key_q  <= pwdata[SEED_W-1:0];
				REG_INIT_VECTOR: iv_q   <= pwdata[BYTE_W-1:0];
				REG_WEYL_INCR:   weyl_q <= pwdata[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CIPHER_KEY:  prdata = APB_DATA_W'(key_q);
			REG_INIT_VECTOR: prdata = APB_DATA_W'(iv_q);
			REG_WEYL_INCR:   prdata = APB_DATA_W'(weyl_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.cipher_key     = key_q;
	assign cfg.init_vector    = iv_q;
	assign cfg.weyl_increment = weyl_q;

endmodule

>>> hdl/cxpc_seed.sv
`timescale 1ns / 1ps
// First pipeline stage: seed = key ^ (seq_id * mix) ^ timestamp, initial chain byte.
// Depends on cxpc_pkg.
module cxpc_seed
	import cxpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cxpc_cfg_t         cfg,
	input  logic              valid_in,
	output logic              stall_out,
	input  logic              op,
	input  logic [SEQ_W-1:0]  seq_id,
	input  logic [TS_W-1:0]   timestamp,
	input  logic [DATA_W-1:0] payload_in,
	output logic              valid_out,
	input  logic              stall_in,
	output cxpc_lane_t        lane_out
);

	logic              valid_s1;
	cxpc_lane_t        lane_s1;
	logic              en;
	logic [SEED_W-1:0] mix;

	assign en        = !valid_s1 || !stall_in;
	assign stall_out = !en;
	assign mix       = SEED_W'(seq_id) * SEQ_MIX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			lane_s1.dec   <= op;
			lane_s1.seed  <= cfg.cipher_key ^ mix ^ timestamp;
			lane_s1.chain <= cfg.init_vector ^ seq_id[BYTE_W-1:0];
			lane_s1.data  <= payload_in;
		end
	end

	assign valid_out = valid_s1;
	assign lane_out  = lane_s1;

endmodule

>>> hdl/cxpc_round.sv
`timescale 1ns / 1ps
// One byte round stage: xorshift + Weyl step, keystream XOR, chain update.
// Depends on cxpc_pkg.
module cxpc_round
	import cxpc_pkg::*;
#(
	parameter int unsigned BYTE_IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cxpc_cfg_t  cfg,
	input  logic       valid_in,
	output logic       stall_out,
	input  cxpc_lane_t lane_in,
	output logic       valid_out,
	input  logic       stall_in,
	output cxpc_lane_t lane_out
);

	localparam int unsigned LO = BYTE_IDX * BYTE_W;

	logic              valid_s1;
	cxpc_lane_t        lane_s1;
	logic              en;
	logic [SEED_W-1:0] seed_nxt;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] o;
	cxpc_lane_t        lane_nxt;

	assign en        = !valid_s1 || !stall_in;
	assign stall_out = !en;

	always_comb begin
		seed_nxt             = xorshift(lane_in.seed) + cfg.weyl_increment;
		b                    = lane_in.data[LO +: BYTE_W];
		o                    = seed_nxt[BYTE_W-1:0] ^ lane_in.chain ^ b;
		lane_nxt             = lane_in;
		lane_nxt.seed        = seed_nxt;
		lane_nxt.chain       = lane_in.dec ? b : o;
		lane_nxt.data[LO +: BYTE_W] = o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			lane_s1 <= lane_nxt;
		end
	end

	assign valid_out = valid_s1;
	assign lane_out  = lane_s1;

endmodule

>>> hdl/cxpc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for chained_xorshift_packet_cipher_core, attached by bind.
// Depends on cxpc_pkg.
module cxpc_checker
	import cxpc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  pready,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_W-1:0]     payload_out
);

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[APB_ADDR_W-1:2] == REG_CIPHER_KEY) |=>
		(!psel || pwrite || paddr[APB_ADDR_W-1:2] != REG_CIPHER_KEY ||
		 prdata == $past(pwdata)))
		else $error("key readback mismatch");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(payload_out))
		else $error("stalled result changed");

endmodule

bind chained_xorshift_packet_cipher_core cxpc_checker u_cxpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata),
	.pready      (pready),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.payload_out (payload_out)
);
